>>> rtl/rfalu_pkg.sv
// Shared types and constants for the register-file ALU.
// No dependencies; imported by every module of the block.
package rfalu_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned SHAMT_W   = 5;
  localparam int unsigned KIND_W    = 4;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SUC = 4'd3,
    OP_RSB = 4'd4,
    OP_RSC = 4'd5,
    OP_LSL = 4'd6,
    OP_LSR = 4'd7,
    OP_AND = 4'd8,
    OP_OR  = 4'd9,
    OP_XOR = 4'd10,
    OP_NOT = 4'd11,
    OP_MIN = 4'd12,
    OP_MAX = 4'd13,
    OP_CLR = 4'd14,
    OP_SET = 4'd15
  } alu_op_t;

  typedef logic [DATA_W-1:0]    word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // ALU outcome handed to the commit logic
  typedef struct packed {
    word_t value;
    logic  carry;
  } alu_res_t;

endpackage

>>> rtl/rfalu_regfile.sv
// Register bank: array storage with per-entry valid bits (reset reads zero),
// registered reads and same-cycle write forwarding. Uses rfalu_pkg.
module rfalu_regfile
  import rfalu_pkg::*;
#(
  parameter int unsigned NUM_REGS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     rd_en,
  input  reg_idx_t rd1_idx,
  input  reg_idx_t rd2_idx,
  input  logic     wr_en,
  input  reg_idx_t wr_idx,
  input  word_t    wr_data,
  output word_t    rd1_data,
  output word_t    rd2_data
);

  localparam int unsigned AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  word_t               regs_r [NUM_REGS];
  logic [NUM_REGS-1:0] valid_r;
  logic [NUM_REGS-1:0] valid_nxt;

  logic [AW+REG_IDX_W-1:0] rd1_ext, rd2_ext, wr_ext;
  logic [AW-1:0]           rd1_addr, rd2_addr, wr_addr;
  logic                    rd1_ok, rd2_ok, wr_ok;
  logic                    fwd1, fwd2;

  word_t rd1_q_r, rd2_q_r, fwd_data_r;
  logic  rd1_ok_r, rd2_ok_r, fwd1_r, fwd2_r;

  assign rd1_ext  = {{AW{1'b0}}, rd1_idx};
  assign rd2_ext  = {{AW{1'b0}}, rd2_idx};
  assign wr_ext   = {{AW{1'b0}}, wr_idx};
  assign rd1_addr = rd1_ext[AW-1:0];
  assign rd2_addr = rd2_ext[AW-1:0];
  assign wr_addr  = wr_ext[AW-1:0];

  // indexes past the bank read as zero and drop writes
  assign rd1_ok = (32'(rd1_idx) < NUM_REGS);
  assign rd2_ok = (32'(rd2_idx) < NUM_REGS);
  assign wr_ok  = (32'(wr_idx) < NUM_REGS);

  // a write landing on the same edge as the read is not yet in the array
  assign fwd1 = wr_en && wr_ok && (wr_idx == rd1_idx);
  assign fwd2 = wr_en && wr_ok && (wr_idx == rd2_idx);

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en && wr_ok) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      regs_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd1_q_r    <= regs_r[rd1_addr];
      rd2_q_r    <= regs_r[rd2_addr];
      rd1_ok_r   <= rd1_ok && valid_r[rd1_addr];
      rd2_ok_r   <= rd2_ok && valid_r[rd2_addr];
      fwd1_r     <= fwd1;
      fwd2_r     <= fwd2;
      fwd_data_r <= wr_data;
    end
  end

  assign rd1_data = fwd1_r ? fwd_data_r : (rd1_ok_r ? rd1_q_r : '0);
  assign rd2_data = fwd2_r ? fwd_data_r : (rd2_ok_r ? rd2_q_r : '0);

endmodule

>>> rtl/rfalu_alu.sv
// Combinational ALU: one shared 32-bit adder for the six arithmetic ops,
// shifts, logic, unsigned min/max and bit clear/set. Uses rfalu_pkg.
module rfalu_alu
  import rfalu_pkg::*;
(
  input  alu_op_t  op,
  input  word_t    a,
  input  word_t    b,
  input  logic     carry_in,
  output alu_res_t res
);

  word_t                add_x, add_y, sum, bit_mask;
  logic                 add_cin;
  logic [SHAMT_W-1:0]   sh;
  logic                 arith;

  assign sh       = b[SHAMT_W-1:0];
  assign bit_mask = word_t'(1) << sh;
  assign sum      = add_x + add_y + word_t'(add_cin);

  // x + y + cin covers every add/subtract form: x - y - c = x + ~y + !c
  always_comb begin
    add_x   = a;
    add_y   = b;
    add_cin = 1'b0;
    arith   = 1'b1;
    unique case (op)
      OP_ADD: add_cin = 1'b0;
      OP_ADC: add_cin = carry_in;
      OP_SUB: begin
        add_y   = ~b;
        add_cin = 1'b1;
      end
      OP_SUC: begin
        add_y   = ~b;
        add_cin = ~carry_in;
      end
      OP_RSB: begin
        add_x   = b;
        add_y   = ~a;
        add_cin = 1'b1;
      end
      OP_RSC: begin
        add_x   = b;
        add_y   = ~a;
        add_cin = ~carry_in;
      end
      default: arith = 1'b0;
    endcase
  end

  always_comb begin
    // arithmetic ops load carry from the top result bit, others keep it
    res.carry = arith ? sum[DATA_W-1] : carry_in;
    unique case (op)
      OP_ADD, OP_ADC, OP_SUB,
      OP_SUC, OP_RSB, OP_RSC: res.value = sum;
      OP_LSL: res.value = a << sh;
      OP_LSR: res.value = a >> sh;
      OP_AND: res.value = a & b;
      OP_OR:  res.value = a | b;
      OP_XOR: res.value = a ^ b;
      OP_NOT: res.value = ~a;
      OP_MIN: res.value = (a < b) ? a : b;
      OP_MAX: res.value = (a > b) ? a : b;
      OP_CLR: res.value = a & ~bit_mask;
      OP_SET: res.value = a | bit_mask;
      default: res.value = a;
    endcase
  end

endmodule

>>> rtl/register_file_alu_with_carry.sv
// Register-file ALU with carry flag, top level.
// The accepted transaction is held in the execute stage; its result is registered onto out_* when it retires.
// Throughput: one transaction per cycle while out_ready holds; register read, ALU and write-back share one stage.
// Reset (rst_n, synchronous, active low): registers read as zero, carry clear, channels empty.
// Depends on rfalu_pkg, rfalu_regfile, rfalu_alu.
module register_file_alu_with_carry
  import rfalu_pkg::*;
#(
  parameter int unsigned NUM_REGS  = 32,
  parameter int unsigned IMM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [REG_IDX_W-1:0] in_dest_reg,
  input  logic [REG_IDX_W-1:0] in_src1_reg,
  input  logic [REG_IDX_W-1:0] in_src2_reg,
  input  logic                 in_use_immediate,
  input  logic [IMM_W-1:0]     in_immediate,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_result_value,
  output logic                 out_carry_out
);

  // Only the low IMM_WIDTH bits of the immediate take part.
  localparam logic [63:0] IMM_MASK64 = (IMM_WIDTH >= 64) ? '1 :
                                       ((64'd1 << IMM_WIDTH) - 64'd1);
  localparam word_t       IMM_MASK   = IMM_MASK64[DATA_W-1:0];

  // ---------------------------------------------------------------------
  // Execute stage: decoded fields of the accepted transaction. The bank
  // reads are captured on the same edge inside the register file.
  // ---------------------------------------------------------------------
  logic     ex_valid_r, ex_valid_nxt;
  alu_op_t  ex_op_r;
  reg_idx_t ex_dest_r;
  logic     ex_use_imm_r;
  logic [IMM_W-1:0] ex_imm_r;

  logic     carry_r, carry_nxt;

  // output register
  logic     out_valid_r, out_valid_nxt;
  word_t    out_value_r;
  logic     out_carry_r;

  logic     in_accept;
  logic     commit;
  word_t    op_a, op_b, rd2_data, imm_ext;
  alu_res_t alu_res;

  // The execute stage retires whenever the output register is free or is
  // being emptied this cycle; retiring also frees the stage for a new
  // transaction on the same edge.
  assign commit    = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !ex_valid_r || commit;
  assign in_accept = in_valid && in_ready;

  // Register bank. Write-back happens at commit; a read issued on that
  // same edge picks up the written value through the forwarding path.
  rfalu_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd1_idx  (in_src1_reg),
    .rd2_idx  (in_src2_reg),
    .wr_en    (commit),
    .wr_idx   (ex_dest_r),
    .wr_data  (alu_res.value),
    .rd1_data (op_a),
    .rd2_data (rd2_data)
  );

  assign imm_ext = {{(DATA_W-IMM_W){1'b0}}, ex_imm_r} & IMM_MASK;
  assign op_b    = ex_use_imm_r ? imm_ext : rd2_data;

  rfalu_alu u_alu (
    .op       (ex_op_r),
    .a        (op_a),
    .b        (op_b),
    .carry_in (carry_r),
    .res      (alu_res)
  );

  // ---------------------------------------------------------------------
  // Control next-state
  // ---------------------------------------------------------------------
  always_comb begin
    ex_valid_nxt = ex_valid_r;
    if (in_accept) begin
      ex_valid_nxt = 1'b1;
    end else if (commit) begin
      ex_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // carry only moves when a transaction retires
  assign carry_nxt = commit ? alu_res.carry : carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      carry_r     <= 1'b0;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      out_valid_r <= out_valid_nxt;
      carry_r     <= carry_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_op_r      <= alu_op_t'(in_kind);
      ex_dest_r    <= in_dest_reg;
      ex_use_imm_r <= in_use_immediate;
      ex_imm_r     <= in_immediate;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_value_r <= alu_res.value;
      out_carry_r <= alu_res.carry;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_carry_out    = out_carry_r;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for register_file_alu_with_carry: a shadow register bank
// predicts every write-back and the carry flag. The monitor compares each result in order.
// Depends on rfalu_pkg and the register_file_alu_with_carry top level.
module testbench;
  import rfalu_pkg::*;

  localparam int RANDOM_ITEMS     = 380;
  localparam int PRESSURE_ITEMS   = 30;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES    = 5;   // idle time after the last result before the verdict
  localparam int RESET_CYCLES     = 9;

  // Shadow copy of the register bank and carry flag, plus the in-order store of
  // write-backs still to be seen on the result channel.
  class alu_result_board;
    word_t    shadow_regs [32];
    logic     shadow_carry;
    alu_res_t pending_results [$];
    int       mismatch_count;

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      shadow_carry   = 1'b0;
      mismatch_count = 0;
    endfunction

    // Executes one instruction against the shadow state and returns what it writes.
    function alu_res_t execute_op(alu_op_t op, reg_idx_t rd, reg_idx_t rs1, reg_idx_t rs2,
                                  logic use_imm, logic [IMM_W-1:0] imm);
      word_t              a, b, r;
      logic [SHAMT_W-1:0] sh;
      logic               c;
      bit                 arith;
      alu_res_t           res;
      // all operands are read before the write, so rd may alias a source
      a     = shadow_regs[rs1];
      b     = use_imm ? word_t'(imm) : shadow_regs[rs2];
      c     = shadow_carry;
      sh    = b[SHAMT_W-1:0];
      arith = 1'b0;
      case (op)
        OP_ADD: begin r = a + b;     arith = 1'b1; end
        OP_ADC: begin r = a + b + c; arith = 1'b1; end
        OP_SUB: begin r = a - b;     arith = 1'b1; end
        OP_SUC: begin r = a - b - c; arith = 1'b1; end
        OP_RSB: begin r = b - a;     arith = 1'b1; end
        OP_RSC: begin r = b - a - c; arith = 1'b1; end
        OP_LSL: r = a << sh;
        OP_LSR: r = a >> sh;
        OP_AND: r = a & b;
        OP_OR:  r = a | b;
        OP_XOR: r = a ^ b;
        OP_NOT: r = ~a;
        OP_MIN: r = (a < b) ? a : b;
        OP_MAX: r = (a > b) ? a : b;
        OP_CLR: r = a & ~(word_t'(1) << sh);
        default: r = a | (word_t'(1) << sh);
      endcase
      // carry follows bit 31 of arithmetic results only
      if (arith) shadow_carry = r[DATA_W-1];
      shadow_regs[rd] = r;
      res.value = r;
      res.carry = shadow_carry;
      return res;
    endfunction

    function void note_instruction(alu_op_t op, reg_idx_t rd, reg_idx_t rs1, reg_idx_t rs2,
                                   logic use_imm, logic [IMM_W-1:0] imm);
      pending_results.push_back(execute_op(op, rd, rs1, rs2, use_imm, imm));
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_result(word_t value, logic carry);
      alu_res_t exp_res;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%08h/%b with no instruction outstanding",
                                  value, carry));
      end else begin
        exp_res = pending_results.pop_front();
        if (value !== exp_res.value)
          report_mismatch($sformatf("result_value 0x%08h, expected 0x%08h",
                                    value, exp_res.value));
        if (carry !== exp_res.carry)
          report_mismatch($sformatf("carry_out %b, expected %b", carry, exp_res.carry));
      end
    endtask
  endclass

  // Clock, reset and every DUT input start at known values.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind          = '0;
  logic [REG_IDX_W-1:0] in_dest_reg      = '0;
  logic [REG_IDX_W-1:0] in_src1_reg      = '0;
  logic [REG_IDX_W-1:0] in_src2_reg      = '0;
  logic                 in_use_immediate = 1'b0;
  logic [IMM_W-1:0]     in_immediate     = '0;

  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [DATA_W-1:0]    out_result_value;
  logic                 out_carry_out;

  // Handshake between the sender and the receiver for the long back-pressure window.
  bit hold_off_request = 1'b0;
  bit hold_active      = 1'b0;

  alu_result_board results_board = new();

  always #5 clk = ~clk;

  register_file_alu_with_carry dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_dest_reg      (in_dest_reg),
    .in_src1_reg      (in_src1_reg),
    .in_src2_reg      (in_src2_reg),
    .in_use_immediate (in_use_immediate),
    .in_immediate     (in_immediate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_carry_out    (out_carry_out)
  );

  // Monitor: sees pre-edge values of both channels. The input transaction is noted
  // before the result is checked so a result on the same edge as its own input would also line up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        results_board.note_instruction(alu_op_t'(in_kind), in_dest_reg, in_src1_reg,
                                       in_src2_reg, in_use_immediate, in_immediate);
      if (out_valid && out_ready)
        results_board.check_result(out_result_value, out_carry_out);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Offers one instruction and holds it until accepted, then idles for gap cycles.
  // in_valid stays high between back-to-back transactions.
  task automatic send_instr(alu_op_t op, reg_idx_t rd, reg_idx_t rs1, reg_idx_t rs2,
                            logic use_imm, logic [IMM_W-1:0] imm, int gap);
    in_valid         <= 1'b1;
    in_kind          <= op;
    in_dest_reg      <= rd;
    in_src1_reg      <= rs1;
    in_src2_reg      <= rs2;
    in_use_immediate <= use_imm;
    in_immediate     <= imm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register index: mostly anywhere, sometimes a small pool so instructions chain.
  function automatic reg_idx_t pick_reg();
    if ($urandom_range(0, 9) < 3) return reg_idx_t'($urandom_range(0, 3));
    return reg_idx_t'($urandom_range(0, 31));
  endfunction

  function automatic logic [IMM_W-1:0] pick_imm();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return IMM_W'($urandom_range(0, 65535));
    if (roll < 8) return IMM_W'($urandom_range(0, 31));   // shift / bit positions
    if (roll < 9) return '0;
    return '1;
  endfunction

  task automatic send_random_instr(int gap);
    send_instr(alu_op_t'($urandom_range(0, 15)), pick_reg(), pick_reg(), pick_reg(),
               logic'($urandom_range(0, 1)), pick_imm(), gap);
  endtask

  // Sender stops offering and waits until every write-back has been seen.
  // It first waits for a clock edge so the monitor has noted the last accepted transaction.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_board.pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, ready-only stretches, and on request one long hold-off
  // so the block backs up and stalls its input.
  initial begin
    int mode;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        out_ready   <= 1'b0;
        hold_active  = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
        hold_active      = 1'b0;
      end else begin
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else if (mode < 9) begin
          out_ready <= ($urandom_range(0, 3) != 0);
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(5, 30)) @(posedge clk);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int block_len;
    int sent;
    bit no_gaps;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: build edge values from the all-zero bank, then hit every op,
    // carry in both states, shift amounts past 31, and dest aliasing a source.
    send_instr(OP_OR,  5'd1,  5'd0,  5'd0,  1'b1, 16'hFFFF, pick_gap());
    send_instr(OP_NOT, 5'd2,  5'd0,  5'd5,  1'b1, 16'h1234, pick_gap()); // operand two ignored
    send_instr(OP_SET, 5'd3,  5'd0,  5'd0,  1'b1, 16'd31,   pick_gap()); // top bit only
    send_instr(OP_ADD, 5'd4,  5'd2,  5'd0,  1'b1, 16'd1,    pick_gap()); // wraps to zero
    send_instr(OP_SUB, 5'd5,  5'd0,  5'd0,  1'b1, 16'd1,    pick_gap()); // borrow, carry set
    send_instr(OP_ADC, 5'd6,  5'd1,  5'd1,  1'b0, 16'h0000, pick_gap()); // carry-in of one
    send_instr(OP_ADD, 5'd8,  5'd3,  5'd0,  1'b0, 16'h5555, pick_gap());
    send_instr(OP_SUC, 5'd9,  5'd0,  5'd0,  1'b1, 16'h0000, pick_gap()); // 0 - 0 - 1
    send_instr(OP_RSC, 5'd10, 5'd1,  5'd0,  1'b1, 16'hFFFF, pick_gap());
    send_instr(OP_RSB, 5'd7,  5'd2,  5'd0,  1'b0, 16'h0000, pick_gap()); // carry clears
    send_instr(OP_ADC, 5'd11, 5'd3,  5'd3,  1'b0, 16'h0000, pick_gap()); // overflows, wraps to zero
    send_instr(OP_LSL, 5'd12, 5'd2,  5'd0,  1'b1, 16'd31,   pick_gap());
    send_instr(OP_LSL, 5'd13, 5'd2,  5'd0,  1'b1, 16'h0020, pick_gap()); // amount wraps to 0
    send_instr(OP_LSR, 5'd14, 5'd3,  5'd0,  1'b1, 16'd31,   pick_gap());
    send_instr(OP_LSR, 5'd15, 5'd2,  5'd2,  1'b0, 16'h0000, pick_gap()); // amount from reg
    send_instr(OP_AND, 5'd16, 5'd2,  5'd0,  1'b1, 16'hAAAA, pick_gap());
    send_instr(OP_XOR, 5'd17, 5'd2,  5'd1,  1'b0, 16'h0000, pick_gap());
    send_instr(OP_MIN, 5'd18, 5'd2,  5'd1,  1'b0, 16'h0000, pick_gap());
    send_instr(OP_MAX, 5'd19, 5'd3,  5'd2,  1'b0, 16'h0000, pick_gap());
    send_instr(OP_MIN, 5'd20, 5'd1,  5'd1,  1'b0, 16'h0000, pick_gap()); // equal operands
    send_instr(OP_CLR, 5'd21, 5'd2,  5'd0,  1'b1, 16'd31,   pick_gap());
    send_instr(OP_CLR, 5'd22, 5'd2,  5'd14, 1'b0, 16'h0000, pick_gap());
    send_instr(OP_SET, 5'd23, 5'd1,  5'd0,  1'b1, 16'h0000, pick_gap());
    send_instr(OP_ADD, 5'd1,  5'd1,  5'd1,  1'b0, 16'h0000, pick_gap()); // rd == rs1 == rs2
    send_instr(OP_OR,  5'd31, 5'd2,  5'd0,  1'b1, 16'h0000, pick_gap());
    send_instr(OP_SUB, 5'd31, 5'd31, 5'd31, 1'b0, 16'hFFFF, pick_gap());

    // Sender pause until the pipe is empty.
    wait_for_results();

    // Back-pressure: receiver holds off while the sender keeps offering transactions.
    hold_off_request = 1'b1;
    while (!hold_active) @(posedge clk);
    for (int i = 0; i < PRESSURE_ITEMS; i++) send_random_instr(0);

    // Random part in blocks; some blocks run back to back with no sender gaps.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      block_len = $urandom_range(20, 40);
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < block_len && sent < RANDOM_ITEMS; i++) begin
        send_random_instr(no_gaps ? 0 : pick_gap());
        sent++;
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (results_board.mismatch_count == 0 && results_board.pending_results.size() == 0)
      $display("register_file_alu_with_carry test passed");
    else
      $display("register_file_alu_with_carry test failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("register_file_alu_with_carry test failed");
    $finish;
  end

endmodule
